>>> sv/wsbd_pkg.sv
package wsbd_pkg;

    localparam int RING_DEPTH = 64;

    localparam int TIME_W      = 32;
    localparam int ALEVEL_W    = 15;
    localparam int VLEVEL_W    = 16;
    localparam int MIN_W       = 7;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    // Command codes carried in the cmd field.
    localparam logic [1:0] CMD_QUERY = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_WINDOW_TICKS      = 2'd0;
    localparam logic [1:0] REG_MIN_SAMPLES       = 2'd1;
    localparam logic [1:0] REG_SILENCE_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_BLACK_THRESHOLD   = 2'd3;

    localparam logic [TIME_W-1:0]   WINDOW_TICKS_RST      = 32'd2000000;
    localparam logic [MIN_W-1:0]    MIN_SAMPLES_RST       = 7'd4;
    localparam logic [ALEVEL_W-1:0] SILENCE_THRESHOLD_RST = 15'd33;
    localparam logic [VLEVEL_W-1:0] BLACK_THRESHOLD_RST   = 16'd655;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [TIME_W-1:0]   event_time;
        logic signed [15:0]  audio_level;
        logic                brightness_present;
        logic [VLEVEL_W-1:0] brightness;
    } in_t;

    typedef struct packed {
        logic              audio_silent;
        logic              visual_black;
        logic [TIME_W-1:0] audio_span;
        logic [TIME_W-1:0] visual_span;
    } out_t;

    typedef struct packed {
        logic [TIME_W-1:0]   window_ticks;
        logic [MIN_W-1:0]    min_samples;
        logic [ALEVEL_W-1:0] silence_threshold;
        logic [VLEVEL_W-1:0] black_threshold;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic prep;
        logic scan;
        logic finish;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [TIME_W-1:0]   stamp;
        logic [ALEVEL_W-1:0] level;
    } aentry_t;

    typedef struct packed {
        logic [TIME_W-1:0]   stamp;
        logic [VLEVEL_W-1:0] level;
    } ventry_t;

    // Magnitude of a signed Q1.15 peak; full-scale negative saturates.
    function automatic logic [ALEVEL_W-1:0] audio_mag(input logic signed [15:0] raw);
        logic [15:0] neg;
        neg = 16'(-raw);
        if (!raw[15]) begin
            audio_mag = raw[ALEVEL_W-1:0];
        end else if (neg[15]) begin
            audio_mag = '1;
        end else begin
            audio_mag = neg[ALEVEL_W-1:0];
        end
    endfunction

endpackage

>>> sv/wsbd_ram.sv
module wsbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/wsbd_ctrl.sv
module wsbd_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  wsbd_pkg::sts_t  sts,
    output wsbd_pkg::ctl_t  ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        ctl        = '0;
        ctl.load   = (state_reg == ST_IDLE) && s_valid;
        ctl.prep   = (state_reg == ST_PREP);
        ctl.scan   = (state_reg == ST_SCAN);
        ctl.finish = (state_reg == ST_FINISH) && sts.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (sts.scan_last) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (sts.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/wsbd_datapath.sv
module wsbd_datapath #(
    parameter int RING_DEPTH = wsbd_pkg::RING_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  wsbd_pkg::in_t  s_data,
    input  wsbd_pkg::cfg_t cfg,
    input  wsbd_pkg::ctl_t ctl,
    output wsbd_pkg::sts_t sts,
    output logic           m_valid,
    input  logic           m_ready,
    output wsbd_pkg::out_t m_data
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int TW = wsbd_pkg::TIME_W;
    localparam int AL = wsbd_pkg::ALEVEL_W;
    localparam int VL = wsbd_pkg::VLEVEL_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(RING_DEPTH);

    wsbd_pkg::in_t    item_reg;
    logic [AW-1:0]    addr_reg;
    logic             rd_vld_reg;
    logic [AW-1:0]    a_wpos_reg, v_wpos_reg;
    logic [FW-1:0]    a_fill_reg, v_fill_reg;

    logic [FW-1:0]    a_cnt_reg, v_cnt_reg;
    logic [AL-1:0]    a_max_reg;
    logic [VL-1:0]    v_max_reg;
    logic [TW-1:0]    a_old_reg, v_old_reg;

    logic             m_valid_reg;
    wsbd_pkg::out_t   m_data_reg;

    wsbd_pkg::aentry_t a_wr, a_rd;
    wsbd_pkg::ventry_t v_wr, v_rd;
    logic              a_we, v_we;
    logic              is_store, is_clear;
    logic              a_hit, v_hit;
    logic              v_seen;
    logic [TW-1:0]     now;
    logic              silent, black;
    logic [TW-1:0]     a_span, v_span;

    assign now      = item_reg.event_time;
    assign is_store = (item_reg.cmd == wsbd_pkg::CMD_STORE);
    assign is_clear = (item_reg.cmd == wsbd_pkg::CMD_CLEAR);

    assign a_we        = ctl.prep && is_store;
    assign v_we        = ctl.prep && is_store && item_reg.brightness_present;
    assign a_wr.stamp  = now;
    assign a_wr.level  = wsbd_pkg::audio_mag(item_reg.audio_level);
    assign v_wr.stamp  = now;
    assign v_wr.level  = item_reg.brightness;

    wsbd_ram #(.WIDTH($bits(wsbd_pkg::aentry_t)), .DEPTH(RING_DEPTH)) u_audio_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_wpos_reg),
        .wdata (a_wr),
        .raddr (addr_reg),
        .rdata (a_rd)
    );

    wsbd_ram #(.WIDTH($bits(wsbd_pkg::ventry_t)), .DEPTH(RING_DEPTH)) u_visual_ram (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (v_wpos_reg),
        .wdata (v_wr),
        .raddr (addr_reg),
        .rdata (v_rd)
    );

    // An entry counts when it is not in the future and lies inside the window.
    assign a_hit = rd_vld_reg && (a_rd.stamp <= now) && ((now - a_rd.stamp) < cfg.window_ticks);
    assign v_hit = rd_vld_reg && (v_rd.stamp <= now) && ((now - v_rd.stamp) < cfg.window_ticks);

    // The brightness ring only fills through stores with a brightness sample.
    assign v_seen = (v_fill_reg != '0);

    assign silent = (32'(a_cnt_reg) >= 32'(cfg.min_samples)) &&
                    (a_max_reg < cfg.silence_threshold);
    assign black  = v_seen && (32'(v_cnt_reg) >= 32'(cfg.min_samples)) &&
                    (v_max_reg < cfg.black_threshold);
    assign a_span = (a_cnt_reg != '0) ? (now - a_old_reg) : '0;
    assign v_span = (v_seen && (v_cnt_reg != '0)) ? (now - v_old_reg) : '0;

    assign sts.scan_last = (addr_reg == LAST_ADDR);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Control state: write positions, fill counts, read pipeline, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_wpos_reg  <= '0;
            v_wpos_reg  <= '0;
            a_fill_reg  <= '0;
            v_fill_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctl.prep && is_clear) begin
                a_wpos_reg <= '0;
                v_wpos_reg <= '0;
                a_fill_reg <= '0;
                v_fill_reg <= '0;
            end
            if (a_we) begin
                a_wpos_reg <= (a_wpos_reg == LAST_ADDR) ? '0 : a_wpos_reg + 1'b1;
                if (a_fill_reg != FULL_FILL) begin
                    a_fill_reg <= a_fill_reg + 1'b1;
                end
            end
            if (v_we) begin
                v_wpos_reg <= (v_wpos_reg == LAST_ADDR) ? '0 : v_wpos_reg + 1'b1;
                if (v_fill_reg != FULL_FILL) begin
                    v_fill_reg <= v_fill_reg + 1'b1;
                end
            end
            // Both rings fill from slot zero after a clear, so the fill count
            // marks which slots hold samples; this flag uses the audio fill count only.
            rd_vld_reg <= ctl.scan && (FW'(addr_reg) < a_fill_reg);
            if (ctl.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Visual entries have their own fill count; slots beyond it are masked here.
    logic v_slot_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_slot_reg <= 1'b0;
        end else begin
            v_slot_reg <= ctl.scan && (FW'(addr_reg) < v_fill_reg);
        end
    end

    // Payload: item, scan address, window accumulators and result.
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            item_reg  <= s_data;
            addr_reg  <= '0;
            a_cnt_reg <= '0;
            v_cnt_reg <= '0;
            a_max_reg <= '0;
            v_max_reg <= '0;
            a_old_reg <= s_data.event_time;
            v_old_reg <= s_data.event_time;
        end else begin
            if (ctl.scan && !sts.scan_last) begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (a_hit && rd_vld_reg) begin
                a_cnt_reg <= a_cnt_reg + 1'b1;
                if (a_rd.level > a_max_reg) begin
                    a_max_reg <= a_rd.level;
                end
                if (a_rd.stamp < a_old_reg) begin
                    a_old_reg <= a_rd.stamp;
                end
            end
            if (v_hit && v_slot_reg) begin
                v_cnt_reg <= v_cnt_reg + 1'b1;
                if (v_rd.level > v_max_reg) begin
                    v_max_reg <= v_rd.level;
                end
                if (v_rd.stamp < v_old_reg) begin
                    v_old_reg <= v_rd.stamp;
                end
            end
        end
        if (ctl.finish) begin
            m_data_reg.audio_silent <= silent;
            m_data_reg.visual_black <= black;
            m_data_reg.audio_span   <= a_span;
            m_data_reg.visual_span  <= v_span;
        end
    end

endmodule

>>> sv/windowed_silence_black_detector_top.sv
// Channel      Direction  Handshake        Payload
// s_ (input)   in         s_valid/s_ready  wsbd_pkg::in_t  : cmd, time, audio, brightness
// m_ (result)  out        m_valid/m_ready  wsbd_pkg::out_t : silent, black, two spans
// APB config   in/out     psel/penable     four registers at byte addresses 0, 4, 8, 12
//
// Each transaction runs from acceptance through these steps before the next
// can be accepted: take the item, clear or store, scan one ring slot per
// cycle, drain the RAM read and register the result. Reset (aresetn low,
// synchronous) empties both rings and reloads the register defaults. A stalled
// result holds in the output register while the next transaction is accepted;
// only its final step waits.
module windowed_silence_black_detector_top #(
    parameter int RING_DEPTH = wsbd_pkg::RING_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  wsbd_pkg::in_t                       s_data,

    output logic                                m_valid,
    input  logic                                m_ready,
    output wsbd_pkg::out_t                      m_data,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wsbd_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [wsbd_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [wsbd_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    wsbd_pkg::cfg_t cfg_reg;
    wsbd_pkg::ctl_t ctl;
    wsbd_pkg::sts_t sts;
    logic           cfg_wr;
    logic [1:0]     cfg_idx;

    // The port never stretches an access, so every write completes in its
    // access cycle. The register index is the word address.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    // Configuration registers. Software must write them only while the block is idle;
    // the block does not enforce it. Then they stay constant during a transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_ticks      <= wsbd_pkg::WINDOW_TICKS_RST;
            cfg_reg.min_samples       <= wsbd_pkg::MIN_SAMPLES_RST;
            cfg_reg.silence_threshold <= wsbd_pkg::SILENCE_THRESHOLD_RST;
            cfg_reg.black_threshold   <= wsbd_pkg::BLACK_THRESHOLD_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                wsbd_pkg::REG_WINDOW_TICKS: begin
                    cfg_reg.window_ticks <= pwdata;
                end
                wsbd_pkg::REG_MIN_SAMPLES: begin
                    cfg_reg.min_samples <= pwdata[wsbd_pkg::MIN_W-1:0];
                end
                wsbd_pkg::REG_SILENCE_THRESHOLD: begin
                    cfg_reg.silence_threshold <= pwdata[wsbd_pkg::ALEVEL_W-1:0];
                end
                wsbd_pkg::REG_BLACK_THRESHOLD: begin
                    cfg_reg.black_threshold <= pwdata[wsbd_pkg::VLEVEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read data is the register's value, zero-extended to the bus width.
    always_comb begin
        case (cfg_idx)
            wsbd_pkg::REG_WINDOW_TICKS:      prdata = cfg_reg.window_ticks;
            wsbd_pkg::REG_MIN_SAMPLES:       prdata = 32'(cfg_reg.min_samples);
            wsbd_pkg::REG_SILENCE_THRESHOLD: prdata = 32'(cfg_reg.silence_threshold);
            wsbd_pkg::REG_BLACK_THRESHOLD:   prdata = 32'(cfg_reg.black_threshold);
            default:                         prdata = '0;
        endcase
    end

    // The controller sequences each transaction: take, clear or store, scan,
    // drain, emit. It talks to the datapath only through ctl and sts.
    wsbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    // The datapath holds the two ring RAMs, their write positions and fill
    // counts, the window accumulators and the result register.
    wsbd_datapath #(.RING_DEPTH(RING_DEPTH)) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .ctl     (ctl),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
